// ===== design/prl_pkg.sv =====
package prl_pkg;

  // Table geometry and field widths.
  localparam int TableDepth = 1024;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int AddrW      = 48;
  localparam int CountW     = SlotW + 1;
  localparam int CfgIdxW    = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_SIZE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENTRY_COUNT = 2'd1;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One queued item as handed from the front to the back.
  typedef struct packed {
    logic             kind;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] source;
    logic             patch_sel;
    logic [AddrW-1:0] offset;
  } item_t;

  // Lookup engine states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CMP,
    ST_SRC,
    ST_FIN
  } state_t;

endpackage

// ===== design/prl_ram.sv =====
module prl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/prl_front.sv =====
module prl_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  prl_pkg::item_t        in_item,
  output logic                  q_valid,
  output prl_pkg::item_t        q_item,
  input  logic                  q_pop
);
  import prl_pkg::*;

  item_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  // Two-word queue decoupling the input from the lookup engine.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_item;
    end
  end

  // Pointer and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue fill count overflowed");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> count != 2'd0)
    else $error("pop from an empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !q_pop) |=> count == 2'd2)
    else $error("full queue lost a word");

endmodule

// ===== design/prl_back.sv =====
module prl_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [prl_pkg::AddrW-1:0]   image_size,
  input  logic [prl_pkg::CountW-1:0]  entry_count,
  input  logic                        q_valid,
  input  prl_pkg::item_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        in_range,
  output logic [prl_pkg::SlotW-1:0]   found_slot,
  output logic                        use_patch,
  output logic [prl_pkg::AddrW-1:0]   translated_offset,
  output logic [prl_pkg::AddrW-1:0]   bytes_to_boundary
);
  import prl_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [AddrW-1:0] cur_offset;
  logic [SlotW-1:0] idx;
  logic [SlotW-1:0] hit;
  logic [AddrW-1:0] boundary;
  logic [AddrW-1:0] diff;
  logic [SlotW-1:0] last_slot;
  logic             take;
  logic             take_load;
  logic             take_miss;
  logic             take_scan;
  logic             match;
  logic [AddrW-1:0] start_rdata;
  logic [AddrW:0]   src_rdata;

  // Highest live slot, with the count clamped to one and to the depth.
  always_comb begin
    if (entry_count == '0) begin
      last_slot = '0;
    end else if (entry_count > CountW'(TableDepth)) begin
      last_slot = SlotW'(TableDepth - 1);
    end else begin
      last_slot = SlotW'(entry_count - 1'b1);
    end
  end

  // Loads run whenever the engine is idle; lookups also wait for a free result register.
  assign take      = (state == ST_IDLE) && q_valid &&
                     (q_item.kind == KIND_LOAD || !out_valid);
  assign take_load = take && q_item.kind == KIND_LOAD;
  assign take_miss = take && q_item.kind == KIND_LOOKUP && q_item.offset >= image_size;
  assign take_scan = take && q_item.kind == KIND_LOOKUP && q_item.offset < image_size;
  assign q_pop     = take;
  assign match     = (start_rdata <= cur_offset) || (idx == '0);

  prl_ram #(.Width(AddrW), .Depth(TableDepth)) u_start_ram (
    .clk   (clk),
    .we    (take_load),
    .waddr (q_item.slot),
    .wdata (q_item.start),
    .raddr (idx),
    .rdata (start_rdata)
  );

  prl_ram #(.Width(AddrW + 1), .Depth(TableDepth)) u_src_ram (
    .clk   (clk),
    .we    (take_load),
    .waddr (q_item.slot),
    .wdata ({q_item.patch_sel, q_item.source}),
    .raddr (hit),
    .rdata (src_rdata)
  );

  // Next state: scan downward from the last live slot.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take_scan) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_CMP;
      ST_CMP: begin
        state_next = match ? ST_SRC : ST_ADDR;
      end
      ST_SRC:  state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take_scan) begin
          cur_offset <= q_item.offset;
          idx        <= last_slot;
          boundary   <= image_size;
        end
      end
      ST_CMP: begin
        if (match) begin
          hit  <= idx;
          diff <= cur_offset - start_rdata;
        end else begin
          boundary <= start_rdata;
          idx      <= idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_miss || state == ST_FIN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_miss) begin
      in_range          <= 1'b0;
      found_slot        <= '0;
      use_patch         <= 1'b0;
      translated_offset <= '0;
      bytes_to_boundary <= '0;
    end else if (state == ST_FIN) begin
      in_range          <= 1'b1;
      found_slot        <= hit;
      use_patch         <= src_rdata[AddrW];
      translated_offset <= diff + src_rdata[AddrW-1:0];
      bytes_to_boundary <= boundary - cur_offset;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> idx <= last_slot)
    else $error("scan index beyond the live entries");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !out_valid)
    else $error("result register overwritten");
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop)
    else $error("item taken while a lookup is running");

endmodule

// ===== design/patch_relocation_lookup_core.sv =====
// Each scanned entry takes an address step and a compare step on the start table read port.
// A load is written when taken; an offset at or past the image size gives its result in the cycle after it is taken.
// Throughput is one lookup per scan; a two-word queue keeps taking input meanwhile, until it fills.
// Synchronous reset clears control state, image size to 0 and entry count to 1.
module patch_relocation_lookup_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [prl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [prl_pkg::AddrW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [prl_pkg::SlotW-1:0]     entry_slot,
  input  logic [prl_pkg::AddrW-1:0]     entry_start,
  input  logic [prl_pkg::AddrW-1:0]     entry_source,
  input  logic                          entry_from_patch,
  input  logic [prl_pkg::AddrW-1:0]     query_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          in_range,
  output logic [prl_pkg::SlotW-1:0]     found_slot,
  output logic                          use_patch,
  output logic [prl_pkg::AddrW-1:0]     translated_offset,
  output logic [prl_pkg::AddrW-1:0]     bytes_to_boundary
);
  import prl_pkg::*;

  logic [AddrW-1:0]  image_size;
  logic [CountW-1:0] entry_count;
  item_t             in_item;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= '0;
      entry_count <= CountW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_SIZE:  image_size  <= cfg_data;
        CFG_ENTRY_COUNT: entry_count <= cfg_data[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item = '{kind: kind, slot: entry_slot, start: entry_start,
                     source: entry_source, patch_sel: entry_from_patch,
                     offset: query_offset};

  prl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  prl_back u_back (
    .clk               (clk),
    .rst               (rst),
    .image_size        (image_size),
    .entry_count       (entry_count),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .in_range          (in_range),
    .found_slot        (found_slot),
    .use_patch         (use_patch),
    .translated_offset (translated_offset),
    .bytes_to_boundary (bytes_to_boundary)
  );

endmodule
